FILE: design/sre_pkg.sv
// Shared types, character codes and helpers for the string repr escape encoder.
// No dependencies; every design file imports this package.
package sre_pkg;

  // Request payloads on the two external channels
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       string_end;
  } out_t;

  // Width of a decoded code point (four-byte sequence carries 3 + 3 * 6 bits)
  localparam int unsigned CpW = 21;

  // Bytes under decode in the front: up to three held plus the new one
  localparam int unsigned BufDepth = 4;

  // Token kinds passed from the front to the back
  typedef enum logic [1:0] {
    TK_CHAR,  // one literal character
    TK_ESC,   // backslash then ch
    TK_HEX    // backslash, prefix ch, then 2, 4 or 8 hex digits of cp
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e        kind;
    logic [7:0]       ch;
    logic [CpW-1:0]   cp;
    logic             last;   // final token caused by the request
    logic             send;   // closing quote
  } tok_t;

  // Character codes
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_UU     = 8'h55;

  // Token queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = 2;
  localparam int unsigned QCw    = 3;

  // Lowercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) r = 8'h30 + {4'b0000, v};
    else           r = 8'h57 + {4'b0000, v};
    return r;
  endfunction

endpackage

FILE: design/string_repr_escape_encoder.sv
// String repr / ascii() escape encoder, top level. Depends on sre_pkg, sre_front,
// sre_queue and sre_back.
// Throughput: one output character per cycle while the receiver is ready; the front
// takes a new request only after it has handed on every token of the last one.
// Reset (rst_ni low, asynchronous): no open string, nothing held, plain mode.
module string_repr_escape_encoder import sre_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic ascii_mode_q;
  logic ft_valid, ft_ready, qb_valid, qb_ready;
  tok_t ft_tok, qb_tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ascii_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      ascii_mode_q <= cfg_wdata_i;
    end
  end

  sre_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ascii_mode_i (ascii_mode_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .tok_valid_o  (ft_valid),
    .tok_ready_i  (ft_ready),
    .tok_o        (ft_tok)
  );

  sre_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ft_valid),
    .in_ready_o  (ft_ready),
    .in_tok_i    (ft_tok),
    .out_valid_o (qb_valid),
    .out_ready_i (qb_ready),
    .out_tok_o   (qb_tok)
  );

  sre_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (qb_valid),
    .tok_ready_o (qb_ready),
    .tok_i       (qb_tok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: design/sre_queue.sv
// Short token queue that decouples the front (classify) from the back (serialise).
// Depends on sre_pkg.
module sre_queue import sre_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  tok_t in_tok_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output tok_t out_tok_o
);

  tok_t             mem_q [QDepth];
  logic [QAw-1:0]   wr_q, rd_q;
  logic [QCw-1:0]   cnt_q;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != QCw'(QDepth));
  assign out_valid_o = (cnt_q != '0);
  assign out_tok_o   = mem_q[rd_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + QAw'(1);
      if (pop)  rd_q <= rd_q + QAw'(1);
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + QCw'(1);
        2'b01:   cnt_q <= cnt_q - QCw'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: design/sre_front.sv
// Front end: takes input requests, holds an open UTF-8 sequence and classifies
// bytes into escape tokens, one per cycle while the queue has room. Depends on sre_pkg.
module sre_front import sre_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic ascii_mode_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic tok_valid_o,
  input  logic tok_ready_i,
  output tok_t tok_o
);

  typedef enum logic [2:0] {
    F_IDLE,
    F_OPEN,
    F_SCAN,
    F_CLOSE,
    F_FIN
  } state_e;

  state_e      state_q, state_d;
  logic [7:0]  b_q [BufDepth];
  logic [7:0]  b_d [BufDepth];
  logic [2:0]  cnt_q, cnt_d;
  logic        last_q, last_d;
  logic        in_str_q, in_str_d;
  logic        stg_vld_q, stg_vld_d;
  tok_t        stg_q, stg_d;

  logic [7:0]     c;
  logic [2:0]     seq_len;
  logic [2:0]     cons;
  logic           bad, hold;
  logic [CpW-1:0] cp;
  tok_t           tok_new, quote_tok, push_tok;
  logic           can_step, push;

  assign c = b_q[0];

  // Classify the byte at the head of the buffer
  always_comb begin
    tok_new = '{kind: TK_CHAR, ch: c, cp: '0, last: 1'b0, send: 1'b0};
    cons    = 3'd1;
    hold    = 1'b0;
    bad     = 1'b0;
    seq_len = 3'd1;
    cp      = '0;

    if      (c[7:5] == 3'b110)   seq_len = 3'd2;
    else if (c[7:4] == 4'b1110)  seq_len = 3'd3;
    else if (c[7:3] == 5'b11110) seq_len = 3'd4;

    for (int k = 1; k < BufDepth; k++) begin
      if (3'(k) < seq_len && 3'(k) < cnt_q && b_q[k][7:6] != 2'b10) bad = 1'b1;
    end

    case (seq_len)
      3'd2:    cp = {10'b0, c[4:0], b_q[1][5:0]};
      3'd3:    cp = {5'b0, c[3:0], b_q[1][5:0], b_q[2][5:0]};
      3'd4:    cp = {c[2:0], b_q[1][5:0], b_q[2][5:0], b_q[3][5:0]};
      default: cp = '0;
    endcase

    if (!ascii_mode_i || !c[7]) begin
      case (c)
        CH_BSLASH: begin tok_new.kind = TK_ESC; tok_new.ch = CH_BSLASH; end
        CH_QUOTE:  begin tok_new.kind = TK_ESC; tok_new.ch = CH_QUOTE;  end
        CH_LF:     begin tok_new.kind = TK_ESC; tok_new.ch = CH_N;      end
        CH_CR:     begin tok_new.kind = TK_ESC; tok_new.ch = CH_R;      end
        CH_TAB:    begin tok_new.kind = TK_ESC; tok_new.ch = CH_T;      end
        default: begin
          if (ascii_mode_i && (c < CH_SPACE || c == CH_DEL)) begin
            tok_new.kind = TK_HEX;
            tok_new.ch   = CH_X;
            tok_new.cp   = {13'b0, c};
          end
        end
      endcase
    end else if (seq_len != 3'd1 && !bad && cnt_q >= seq_len) begin
      tok_new.kind = TK_HEX;
      tok_new.cp   = cp;
      if      (cp <= CpW'(16'hff))   tok_new.ch = CH_X;
      else if (cp <= CpW'(16'hffff)) tok_new.ch = CH_LU;
      else                           tok_new.ch = CH_UU;
      cons = seq_len;
    end else if (seq_len != 3'd1 && !bad && !last_q) begin
      // sequence still open: keep the bytes for the next request
      hold = 1'b1;
    end else begin
      tok_new.kind = TK_HEX;
      tok_new.ch   = CH_X;
      tok_new.cp   = {13'b0, c};
    end
  end

  assign quote_tok  = '{kind: TK_CHAR, ch: CH_QUOTE, cp: '0, last: 1'b0, send: 1'b0};
  assign can_step   = !stg_vld_q || tok_ready_i;
  assign in_ready_o = (state_q == F_IDLE);

  // The newest token waits in the staging register until the next one shows
  // whether it closes the request.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    in_str_d  = in_str_q;
    stg_vld_d = stg_vld_q;
    stg_d     = stg_q;
    b_d       = b_q;
    push      = 1'b0;
    push_tok  = stg_q;

    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.byte_valid) b_d[cnt_q[1:0]] = in_data_i.data_byte;
          cnt_d    = cnt_q + {2'b00, in_data_i.byte_valid};
          last_d   = in_data_i.last_byte;
          in_str_d = !in_data_i.last_byte;
          state_d  = in_str_q ? F_SCAN : F_OPEN;
        end
      end
      F_OPEN: begin
        if (can_step) begin
          push      = stg_vld_q;
          stg_d     = quote_tok;
          stg_vld_d = 1'b1;
          state_d   = F_SCAN;
        end
      end
      F_SCAN: begin
        if (cnt_q == 3'd0) begin
          state_d = last_q ? F_CLOSE : F_FIN;
        end else if (hold) begin
          state_d = F_FIN;
        end else if (can_step) begin
          push      = stg_vld_q;
          stg_d     = tok_new;
          stg_vld_d = 1'b1;
          cnt_d     = cnt_q - cons;
          case (cons)
            3'd2: begin
              for (int i = 0; i < BufDepth - 2; i++) b_d[i] = b_q[i + 2];
            end
            3'd3: b_d[0] = b_q[3];
            3'd4: b_d = b_q;
            default: begin
              for (int i = 0; i < BufDepth - 1; i++) b_d[i] = b_q[i + 1];
            end
          endcase
        end
      end
      F_CLOSE: begin
        if (can_step) begin
          push       = stg_vld_q;
          stg_d      = quote_tok;
          stg_d.send = 1'b1;
          stg_vld_d  = 1'b1;
          state_d    = F_FIN;
        end
      end
      F_FIN: begin
        push_tok.last = 1'b1;
        if (!stg_vld_q) begin
          state_d = F_IDLE;
        end else begin
          push = 1'b1;
          if (tok_ready_i) begin
            stg_vld_d = 1'b0;
            state_d   = F_IDLE;
          end
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign tok_valid_o = push;
  assign tok_o       = push_tok;

  always_ff @(posedge clk_i) begin
    b_q   <= b_d;
    stg_q <= stg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      cnt_q     <= '0;
      last_q    <= 1'b0;
      in_str_q  <= 1'b0;
      stg_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      last_q    <= last_d;
      in_str_q  <= in_str_d;
      stg_vld_q <= stg_vld_d;
    end
  end

  // Between requests at most three bytes of an open sequence are held
  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_IDLE) |-> (cnt_q <= 3'd3))
    else $error("front: more than three held bytes between requests");

  // No string open means nothing held
  a_closed_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_IDLE && !in_str_q) |-> (cnt_q == 3'd0))
    else $error("front: bytes held with no open string");

  // A token is only handed on when the queue can take it, except the final one
  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && state_q != F_FIN) |-> tok_ready_i)
    else $error("front: staged token overwritten while queue full");

endmodule

FILE: design/sre_back.sv
// Back end: expands escape tokens into output characters, one per cycle while the
// receiver is ready, behind an output register. Depends on sre_pkg.
module sre_back import sre_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic tok_valid_i,
  output logic tok_ready_o,
  input  tok_t tok_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  tok_t        cur_q;
  logic        cur_vld_q;
  logic [3:0]  idx_q;
  out_t        out_q;
  logic        out_vld_q;

  logic [3:0]  ndig, tlen, nib_sel;
  logic [31:0] cp32;
  logic [3:0]  nibble;
  logic [7:0]  ch_out;
  logic        fin, adv, pop;

  always_comb begin
    case (cur_q.ch)
      CH_UU:   ndig = 4'd8;
      CH_LU:   ndig = 4'd4;
      default: ndig = 4'd2;
    endcase
    case (cur_q.kind)
      TK_ESC:  tlen = 4'd2;
      TK_HEX:  tlen = 4'd2 + ndig;
      default: tlen = 4'd1;
    endcase
  end

  // Digits go out most significant first
  assign nib_sel = ndig + 4'd1 - idx_q;
  assign cp32    = {{(32 - CpW){1'b0}}, cur_q.cp};
  assign nibble  = cp32[{nib_sel[2:0], 2'b00} +: 4];

  always_comb begin
    if (cur_q.kind == TK_CHAR)  ch_out = cur_q.ch;
    else if (idx_q == 4'd0)     ch_out = CH_BSLASH;
    else if (idx_q == 4'd1)     ch_out = cur_q.ch;
    else                        ch_out = hex_char(nibble);
  end

  assign fin         = (idx_q == tlen - 4'd1);
  assign adv         = cur_vld_q && (!out_vld_q || out_ready_i);
  assign pop         = tok_valid_i && tok_ready_o;
  assign tok_ready_o = !cur_vld_q || (adv && fin);

  always_ff @(posedge clk_i) begin
    if (pop) cur_q <= tok_i;
    if (adv) begin
      out_q.out_char   <= ch_out;
      out_q.run_last   <= cur_q.last && fin;
      out_q.string_end <= cur_q.send && fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (pop) begin
        cur_vld_q <= 1'b1;
        idx_q     <= '0;
      end else if (adv && fin) begin
        cur_vld_q <= 1'b0;
      end else if (adv) begin
        idx_q <= idx_q + 4'd1;
      end
      if (adv)              out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_vld_q |-> (idx_q < tlen))
    else $error("back: character index past end of token");

  a_end_quote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.string_end) |-> (out_q.run_last && out_q.out_char == CH_QUOTE))
    else $error("back: string end not on a final closing quote");

endmodule

FILE: dv/string_repr_escape_encoder_chk.sv
`timescale 1ns / 100ps
// Scoreboard for the string repr escape encoder: watches the mode register and
// both request channels, predicts the repr text and compares it. Needs sre_pkg.
module string_repr_escape_encoder_chk import sre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  output int unsigned due_o,
  output int unsigned fails_o
);

  localparam int    MaxChars  = 17;
  localparam string HexDigits = "0123456789abcdef";

  // Predictor state
  logic [7:0] held_bytes [3];
  int         held_cnt;
  logic       open_str;
  logic       esc_mode;

  // Bytes under decode for the current request (held bytes first)
  logic [7:0] run_bytes [4];
  int         run_n;

  out_t       burst_q [$];
  out_t       repr_due [$];

  task automatic report(input string msg);
    if (fails_o < 100) $display("%0t ns: %s", $time, msg);
    fails_o++;
  endtask

  function automatic void emit(input logic [7:0] ch, input logic fin);
    out_t c;
    if (burst_q.size() < MaxChars) begin
      c.out_char   = ch;
      c.run_last   = 1'b0;
      c.string_end = fin;
      burst_q.push_back(c);
    end
  endfunction

  function automatic void emit_hex(input logic [7:0] prefix, input logic [31:0] v,
                                   input int digits);
    emit(CH_BSLASH, 1'b0);
    emit(prefix, 1'b0);
    for (int k = digits - 1; k >= 0; k--)
      emit(HexDigits[int'((v >> (4 * k)) & 32'hf)], 1'b0);
  endfunction

  function automatic void emit_codepoint(input logic [31:0] cp);
    if (cp <= 32'hff)        emit_hex(CH_X, cp, 2);
    else if (cp <= 32'hffff) emit_hex(CH_LU, cp, 4);
    else                     emit_hex(CH_UU, cp, 8);
  endfunction

  function automatic void emit_plain(input logic [7:0] c);
    case (c)
      CH_BSLASH: begin emit(CH_BSLASH, 1'b0); emit(CH_BSLASH, 1'b0); end
      CH_QUOTE:  begin emit(CH_BSLASH, 1'b0); emit(CH_QUOTE, 1'b0); end
      CH_LF:     begin emit(CH_BSLASH, 1'b0); emit(CH_N, 1'b0); end
      CH_CR:     begin emit(CH_BSLASH, 1'b0); emit(CH_R, 1'b0); end
      CH_TAB:    begin emit(CH_BSLASH, 1'b0); emit(CH_T, 1'b0); end
      default: begin
        if (esc_mode && (c < CH_SPACE || c == CH_DEL)) emit_hex(CH_X, {24'h0, c}, 2);
        else emit(c, 1'b0);
      end
    endcase
  endfunction

  // Lenient UTF-8 walk over run_bytes; an unfinished sequence is held back
  // unless the string ends here.
  function automatic void decode_run(input logic flush);
    int          pos;
    int          len;
    int          avail;
    logic        bad;
    logic [7:0]  c;
    logic [31:0] cp;
    pos = 0;
    while (pos < run_n) begin
      c = run_bytes[pos];
      if (!esc_mode || c < 8'h80) begin
        emit_plain(c);
        pos++;
        continue;
      end
      if ((c & 8'he0) == 8'hc0)      len = 2;
      else if ((c & 8'hf0) == 8'he0) len = 3;
      else if ((c & 8'hf8) == 8'hf0) len = 4;
      else                           len = 1;
      if (len > 1) begin
        avail = run_n - pos;
        bad   = 1'b0;
        for (int k = 1; k < len && k < avail; k++)
          if ((run_bytes[pos + k] & 8'hc0) != 8'h80) bad = 1'b1;
        if (!bad && avail >= len) begin
          case (len)
            2: cp = {21'h0, c[4:0], run_bytes[pos + 1][5:0]};
            3: cp = {16'h0, c[3:0], run_bytes[pos + 1][5:0], run_bytes[pos + 2][5:0]};
            default: cp = {11'h0, c[2:0], run_bytes[pos + 1][5:0],
                           run_bytes[pos + 2][5:0], run_bytes[pos + 3][5:0]};
          endcase
          emit_codepoint(cp);
          pos += len;
          continue;
        end
        if (!bad && !flush) break;
      end
      // bad lead or broken sequence: lead goes out as \xNN, rest replayed
      emit_hex(CH_X, {24'h0, c}, 2);
      pos++;
    end
    held_cnt = 0;
    while (pos < run_n && held_cnt < 3) begin
      held_bytes[held_cnt] = run_bytes[pos];
      held_cnt++;
      pos++;
    end
  endfunction

  function automatic void encode_request(input in_t r);
    burst_q.delete();
    run_n = 0;
    if (!open_str) begin
      emit(CH_QUOTE, 1'b0);
      open_str = 1'b1;
    end
    for (int k = 0; k < held_cnt; k++) begin
      run_bytes[run_n] = held_bytes[k];
      run_n++;
    end
    if (r.byte_valid) begin
      run_bytes[run_n] = r.data_byte;
      run_n++;
    end
    decode_run(r.last_byte);
    if (r.last_byte) begin
      emit(CH_QUOTE, 1'b1);
      open_str = 1'b0;
      held_cnt = 0;
    end
    if (burst_q.size() > 0) burst_q[burst_q.size() - 1].run_last = 1'b1;
    foreach (burst_q[k]) repr_due.push_back(burst_q[k]);
  endfunction

  task automatic check_char(input out_t got);
    out_t want;
    if (repr_due.size() == 0) begin
      report($sformatf("character %02h with nothing expected", got.out_char));
      return;
    end
    want = repr_due.pop_front();
    if (got.out_char !== want.out_char)
      report($sformatf("out_char %02h, want %02h", got.out_char, want.out_char));
    if (got.run_last !== want.run_last)
      report($sformatf("run_last %b, want %b (char %02h)", got.run_last, want.run_last,
                       want.out_char));
    if (got.string_end !== want.string_end)
      report($sformatf("string_end %b, want %b (char %02h)", got.string_end,
                       want.string_end, want.out_char));
  endtask

  // Requests in, then results out, then the register: a write at the same edge
  // as an input would only take effect for the next request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt = 0;
      open_str = 1'b0;
      esc_mode = 1'b0;
      repr_due.delete();
      due_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) encode_request(in_data_i);
      if (out_valid_i && out_ready_i) check_char(out_data_i);
      if (cfg_we_i) esc_mode = cfg_wdata_i;
      due_o = repr_due.size();
    end
  end

endmodule

FILE: dv/string_repr_escape_encoder_tb.sv
`timescale 1ns / 100ps
// Top of the string repr escape encoder testbench: clock, reset, stimulus and
// verdict. Needs sre_pkg, the encoder RTL and string_repr_escape_encoder_chk.
module string_repr_escape_encoder_tb;
  import sre_pkg::*;

  localparam logic        ModePlain  = 1'b0;
  localparam logic        ModeAscii  = 1'b1;
  localparam int unsigned PhaseItems = 75;
  localparam int unsigned HoldCycles = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_t        out_data_o;

  int unsigned due_cnt;
  int unsigned fail_cnt;
  int unsigned sent_cnt;
  int unsigned hold_left;
  bit          calm;
  bit          hold_go;
  logic [7:0]  str_bytes [$];

  string_repr_escape_encoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  string_repr_escape_encoder_chk i_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .due_o       (due_cnt),
    .fails_o     (fail_cnt)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("string_repr_escape_encoder test failed");
    $finish;
  end

  // Receiver: random stalls, a long hold-off on request, none while calm
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HoldCycles;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 14);
      end
    end
  end

  function automatic in_t req(input logic [7:0] b, input logic v, input logic l);
    in_t r;
    r.data_byte  = b;
    r.byte_valid = v;
    r.last_byte  = l;
    return r;
  endfunction

  function automatic logic [7:0] lead_byte(input int unsigned len);
    case (len)
      2:       return 8'hc0 | 8'($urandom_range(31));
      3:       return 8'he0 | 8'($urandom_range(15));
      default: return 8'hf0 | 8'($urandom_range(7));
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  task automatic write_mode(input logic m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic offer(input in_t r);
    if (!calm)
      while ($urandom_range(99) < 14) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (r.byte_valid || r.last_byte) sent_cnt++;
  endtask

  // Sender stops until the text is all out, then waits out any work in flight
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_cnt != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // One character's worth of bytes: mostly well-formed, some broken
  task automatic add_piece();
    int unsigned sel;
    int unsigned len;
    int unsigned keep;
    sel = $urandom_range(99);
    if (sel < 30) begin
      str_bytes.push_back(8'($urandom_range(8'h7e, 8'h20)));
    end else if (sel < 40) begin
      case ($urandom_range(4))
        0: str_bytes.push_back(CH_BSLASH);
        1: str_bytes.push_back(CH_QUOTE);
        2: str_bytes.push_back(CH_LF);
        3: str_bytes.push_back(CH_CR);
        default: str_bytes.push_back(CH_TAB);
      endcase
    end else if (sel < 47) begin
      str_bytes.push_back($urandom_range(1) ? CH_DEL : 8'($urandom_range(8'h1f)));
    end else if (sel < 77) begin
      len = 2 + (sel - 47) / 10;
      str_bytes.push_back(lead_byte(len));
      repeat (len - 1) str_bytes.push_back(cont_byte());
    end else if (sel < 83) begin
      str_bytes.push_back(8'($urandom_range(8'hbf, 8'h80)));
    end else if (sel < 88) begin
      str_bytes.push_back(8'($urandom_range(8'hff, 8'hf8)));
    end else if (sel < 96) begin
      // sequence cut short; at the end of a string it becomes a truncation
      len  = $urandom_range(4, 2);
      keep = $urandom_range(len - 2);
      str_bytes.push_back(lead_byte(len));
      repeat (keep) str_bytes.push_back(cont_byte());
      if ($urandom_range(1)) str_bytes.push_back(8'($urandom_range(8'h7e, 8'h20)));
    end else begin
      str_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic send_string();
    int unsigned pieces;
    logic        tail_flush;
    str_bytes.delete();
    pieces = $urandom_range(8);
    repeat (pieces) add_piece();
    tail_flush = ($urandom_range(99) < 8);
    if (str_bytes.size() == 0) begin
      offer(req(8'($urandom_range(255)), 1'b0, 1'b1));
      return;
    end
    foreach (str_bytes[k]) begin
      if ($urandom_range(99) < 5) offer(req(8'($urandom_range(255)), 1'b0, 1'b0));
      offer(req(str_bytes[k], 1'b1, (k == str_bytes.size() - 1) && !tail_flush));
    end
    if (tail_flush) offer(req(8'($urandom_range(255)), 1'b0, 1'b1));
  endtask

  task automatic rand_phase(input logic m, input bit do_hold, input bit do_calm);
    int unsigned start;
    write_mode(m);
    calm  = do_calm;
    if (do_hold) hold_go = 1'b1;
    start = sent_cnt;
    while (sent_cnt - start < PhaseItems) send_string();
    settle();
    calm  = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // plain repr: empty string, escapes, a raw high byte and the DEL control byte
    write_mode(ModePlain);
    offer(req(8'h00, 1'b0, 1'b1));
    offer(req(8'hff, 1'b1, 1'b0));
    offer(req(CH_BSLASH, 1'b1, 1'b0));
    offer(req(CH_QUOTE, 1'b1, 1'b0));
    offer(req(CH_LF, 1'b1, 1'b0));
    offer(req(CH_CR, 1'b1, 1'b0));
    offer(req(CH_TAB, 1'b1, 1'b0));
    offer(req(8'h01, 1'b0, 1'b0));
    offer(req(CH_DEL, 1'b1, 1'b1));
    settle();

    // ascii: control, stray continuation, 2/3/4-byte forms, broken sequence
    write_mode(ModeAscii);
    offer(req(8'h1f, 1'b1, 1'b0));
    offer(req(8'h80, 1'b1, 1'b0));
    offer(req(8'hc3, 1'b1, 1'b0));
    offer(req(8'ha9, 1'b1, 1'b0));
    offer(req(8'he2, 1'b1, 1'b0));
    offer(req(8'h82, 1'b1, 1'b0));
    offer(req(8'hac, 1'b1, 1'b0));
    offer(req(8'hf0, 1'b1, 1'b0));
    offer(req(8'h9f, 1'b1, 1'b0));
    offer(req(8'h98, 1'b1, 1'b0));
    offer(req(8'h80, 1'b1, 1'b0));
    offer(req(8'hc3, 1'b1, 1'b0));
    offer(req(8'h41, 1'b1, 1'b0));
    offer(req(8'he2, 1'b1, 1'b0));
    offer(req(8'h82, 1'b1, 1'b0));
    settle();

    // mode flips with two bytes held: they now go out raw
    write_mode(ModePlain);
    offer(req(8'h41, 1'b1, 1'b1));
    settle();

    // lead byte cut off by an end-of-string without a byte
    write_mode(ModeAscii);
    offer(req(8'hf4, 1'b1, 1'b0));
    offer(req(8'h00, 1'b0, 1'b1));
    settle();

    rand_phase(ModeAscii, 1'b0, 1'b0);
    rand_phase(ModeAscii, 1'b1, 1'b0);
    rand_phase(ModePlain, 1'b0, 1'b0);
    rand_phase(ModeAscii, 1'b0, 1'b1);
    rand_phase(ModePlain, 1'b0, 1'b0);
    rand_phase(ModeAscii, 1'b0, 1'b0);

    if (fail_cnt == 0) begin
      $display("string_repr_escape_encoder test passed");
    end else begin
      $display("string_repr_escape_encoder test failed");
    end
    $finish;
  end

endmodule
